### rtl/gspe_pkg.sv
// ----------------------------------------------------------------------------
// gspe_pkg
// shared types and constants for the generational slot pool
// ----------------------------------------------------------------------------
package gspe_pkg;

  localparam int SLOTS = 256;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = IDX_W + 1;
  localparam int GEN_W = 32;
  localparam int AA_W  = 24;

  typedef enum logic [1:0] {
    OP_SPAWN  = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_REPORT = 2'd2,
    OP_EXPIRE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_NOREG  = 3'd1,
    ST_FULL   = 3'd2,
    ST_BAD    = 3'd3,
    ST_DEAD   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE, S_POP, S_GRANT, S_READ, S_CHECK,
    S_SCAN, S_SCAN_END, S_VSEL, S_EVICT, S_FIN
  } state_t;

  typedef struct packed {
    logic accept;
    logic grant;
    logic evict;
    logic check;
    logic scan;
    logic full;
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic is_spawn;
    logic region_ok;
    logic idx_bad;
    logic full;
    logic cnt_last;
    logic found;
    logic out_free;
  } stat_t;

endpackage

### rtl/gspe_ram.sv
// ----------------------------------------------------------------------------
// gspe_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module gspe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/gspe_ctrl.sv
// ----------------------------------------------------------------------------
// gspe_ctrl
// request sequencer for the slot pool
// ----------------------------------------------------------------------------
module gspe_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  gspe_pkg::stat_t stat,
  output gspe_pkg::cmd_t  cmd
);

  gspe_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gspe_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      gspe_pkg::S_IDLE: begin
        if (s_tvalid) begin
          if (stat.is_spawn) begin
            if (!stat.region_ok) state_next = gspe_pkg::S_FIN;
            else if (stat.full) state_next = gspe_pkg::S_SCAN;
            else state_next = gspe_pkg::S_POP;
          end else begin
            state_next = stat.idx_bad ? gspe_pkg::S_FIN : gspe_pkg::S_READ;
          end
        end
      end
      gspe_pkg::S_POP:      state_next = gspe_pkg::S_GRANT;
      gspe_pkg::S_GRANT:    state_next = gspe_pkg::S_FIN;
      gspe_pkg::S_READ:     state_next = gspe_pkg::S_CHECK;
      gspe_pkg::S_CHECK:    state_next = gspe_pkg::S_FIN;
      gspe_pkg::S_SCAN:     if (stat.cnt_last) state_next = gspe_pkg::S_SCAN_END;
      gspe_pkg::S_SCAN_END: state_next = gspe_pkg::S_VSEL;
      gspe_pkg::S_VSEL:     state_next = stat.found ? gspe_pkg::S_EVICT : gspe_pkg::S_FIN;
      gspe_pkg::S_EVICT:    state_next = gspe_pkg::S_FIN;
      gspe_pkg::S_FIN:      if (stat.out_free) state_next = gspe_pkg::S_IDLE;
      default:              state_next = gspe_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    unique case (state)
      gspe_pkg::S_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
      end
      gspe_pkg::S_GRANT: cmd.grant = 1'b1;
      gspe_pkg::S_EVICT: begin
        cmd.grant = 1'b1;
        cmd.evict = 1'b1;
      end
      gspe_pkg::S_CHECK: cmd.check = 1'b1;
      gspe_pkg::S_SCAN:  cmd.scan = 1'b1;
      gspe_pkg::S_VSEL:  cmd.full = !stat.found;
      gspe_pkg::S_FIN:   cmd.fin = stat.out_free;
      default: ;
    endcase
  end

endmodule

### rtl/gspe_dp.sv
// ----------------------------------------------------------------------------
// gspe_dp
// slot state, free stack, victim scan and result register
// ----------------------------------------------------------------------------
module gspe_dp (
  input  logic            clk,
  input  logic            rst,
  input  logic [79:0]     s_tdata,
  input  logic [1:0]      s_tuser,
  input  gspe_pkg::cmd_t  cmd,
  output gspe_pkg::stat_t stat,
  output logic            m_tvalid,
  input  logic            m_tready,
  output logic [55:0]     m_tdata,
  output logic [2:0]      m_tuser
);

  localparam int IW = gspe_pkg::IDX_W;
  localparam int CW = gspe_pkg::CNT_W;
  localparam int GW = gspe_pkg::GEN_W;

  logic [1:0]  q_op;
  logic        q_lock;
  logic [7:0]  q_prio;
  logic [8:0]  q_idx;
  logic [31:0] q_hgen;
  logic [7:0]  q_alpha;
  logic [15:0] q_age;

  logic [gspe_pkg::SLOTS-1:0] live, lock, genv, stkv;
  logic [CW-1:0] depth, total, cnt;
  logic [GW-1:0] nextgen, ng_inc;

  logic [2:0]    r_status;
  logic [7:0]    r_index;
  logic [GW-1:0] r_gen;
  logic          r_ev;

  logic          sv, cand_ok, found;
  logic [IW-1:0] cand_idx, best_idx;
  logic [31:0]   best_key, key;

  logic [GW-1:0]            gen_rd, gen_now;
  logic [IW-1:0]            stk_rd, stk_top, gnt;
  logic [7:0]               prio_rd;
  logic [gspe_pkg::AA_W-1:0] aa_rd, aa_wd;
  logic                     aa_we;
  logic [IW-1:0]            aa_wa, ai;

  assign ai      = q_idx[IW-1:0];
  assign ng_inc  = (nextgen + GW'(1) == '0) ? GW'(1) : nextgen + GW'(1);
  assign gen_now = genv[ai] ? gen_rd : '0;
  assign stk_top = stkv[IW'(depth - CW'(1))] ? stk_rd
                                             : IW'(CW'(gspe_pkg::SLOTS) - depth);
  assign gnt     = cmd.evict ? best_idx : stk_top;
  assign key     = {prio_rd, aa_rd[23:16], ~aa_rd[15:0]};
  assign aa_we   = cmd.grant || (cmd.check && q_op == gspe_pkg::OP_REPORT && live[ai]);
  assign aa_wa   = cmd.grant ? gnt : ai;
  assign aa_wd   = cmd.grant ? '0 : {q_alpha, q_age};

  gspe_ram #(.WIDTH(GW), .DEPTH(gspe_pkg::SLOTS)) u_gen (
    .clk(clk), .we(cmd.grant), .waddr(gnt), .wdata(nextgen),
    .raddr(ai), .rdata(gen_rd)
  );

  gspe_ram #(.WIDTH(IW), .DEPTH(gspe_pkg::SLOTS)) u_stk (
    .clk(clk), .we(cmd.check && q_op == gspe_pkg::OP_EXPIRE && live[ai]),
    .waddr(depth[IW-1:0]), .wdata(ai),
    .raddr(IW'(depth - CW'(1))), .rdata(stk_rd)
  );

  gspe_ram #(.WIDTH(8), .DEPTH(gspe_pkg::SLOTS)) u_prio (
    .clk(clk), .we(cmd.grant), .waddr(gnt), .wdata(q_prio),
    .raddr(cnt[IW-1:0]), .rdata(prio_rd)
  );

  gspe_ram #(.WIDTH(gspe_pkg::AA_W), .DEPTH(gspe_pkg::SLOTS)) u_aa (
    .clk(clk), .we(aa_we), .waddr(aa_wa), .wdata(aa_wd),
    .raddr(cnt[IW-1:0]), .rdata(aa_rd)
  );

  always_comb begin
    stat.is_spawn   = s_tuser == gspe_pkg::OP_SPAWN;
    stat.region_ok  = s_tdata[0];
    stat.idx_bad    = int'(s_tdata[18:10]) >= gspe_pkg::SLOTS;
    stat.full       = depth == '0;
    stat.cnt_last   = cnt == CW'(gspe_pkg::SLOTS - 1);
    stat.found      = found;
    stat.out_free   = !m_tvalid || m_tready;
  end

  always_ff @(posedge clk) begin
    sv       <= cmd.scan;
    cand_ok  <= live[cnt[IW-1:0]] && !lock[cnt[IW-1:0]];
    cand_idx <= cnt[IW-1:0];
    if (cmd.accept) begin
      q_op    <= s_tuser;
      q_lock  <= s_tdata[1];
      q_prio  <= s_tdata[9:2];
      q_idx   <= s_tdata[18:10];
      q_hgen  <= s_tdata[50:19];
      q_alpha <= s_tdata[58:51];
      q_age   <= s_tdata[74:59];
      r_gen   <= '0;
      r_ev    <= 1'b0;
      cnt     <= '0;
      found   <= 1'b0;
      if (s_tuser == gspe_pkg::OP_SPAWN) begin
        r_index  <= '0;
        r_status <= s_tdata[0] ? gspe_pkg::ST_OK : gspe_pkg::ST_NOREG;
      end else begin
        r_index  <= s_tdata[17:10];
        r_status <= (int'(s_tdata[18:10]) >= gspe_pkg::SLOTS) ? gspe_pkg::ST_BAD
                                                               : gspe_pkg::ST_OK;
      end
    end
    if (cmd.scan) begin
      cnt <= cnt + CW'(1);
    end
    if (sv && cand_ok && (!found || key < best_key)) begin
      found    <= 1'b1;
      best_key <= key;
      best_idx <= cand_idx;
    end
    if (cmd.grant) begin
      r_index  <= 8'(gnt);
      r_gen    <= nextgen;
      r_ev     <= cmd.evict;
      r_status <= gspe_pkg::ST_OK;
    end
    if (cmd.full) begin
      r_status <= gspe_pkg::ST_FULL;
    end
    if (cmd.check) begin
      r_gen <= gen_now;
      if (q_op == gspe_pkg::OP_LOOKUP) begin
        r_status <= (live[ai] && gen_now == q_hgen) ? gspe_pkg::ST_OK : gspe_pkg::ST_BAD;
      end else begin
        r_status <= live[ai] ? gspe_pkg::ST_OK : gspe_pkg::ST_DEAD;
      end
    end
    if (cmd.fin) begin
      m_tuser <= r_status;
      m_tdata <= {6'd0, total, r_ev, r_gen, r_index};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live     <= '0;
      lock     <= '0;
      genv     <= '0;
      stkv     <= '0;
      depth    <= CW'(gspe_pkg::SLOTS);
      total    <= '0;
      nextgen  <= GW'(1);
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.grant) begin
        live[gnt] <= 1'b1;
        lock[gnt] <= q_lock;
        genv[gnt] <= 1'b1;
        nextgen   <= ng_inc;
        if (!cmd.evict) begin
          depth <= depth - CW'(1);
          total <= total + CW'(1);
        end
      end
      if (cmd.check && q_op == gspe_pkg::OP_EXPIRE && live[ai]) begin
        live[ai]                <= 1'b0;
        stkv[depth[IW-1:0]]     <= 1'b1;
        depth                   <= depth + CW'(1);
        total                   <= total - CW'(1);
      end
      if (cmd.fin) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_conserve: assert property (@(posedge clk) disable iff (rst)
    (CW+1)'(total) + (CW+1)'(depth) == (CW+1)'(gspe_pkg::SLOTS))
    else $error("live count and free depth disagree");
  a_gen_nonzero: assert property (@(posedge clk) disable iff (rst) nextgen != '0)
    else $error("generation counter hit zero");
  a_live_count: assert property (@(posedge clk) disable iff (rst)
    $countones(live) == int'(total))
    else $error("live flags disagree with live total");
  a_fin_free: assert property (@(posedge clk) disable iff (rst)
    cmd.fin |-> (!m_tvalid || m_tready))
    else $error("result overwrote an unsent result");
`endif

endmodule

### rtl/generational_slot_pool_with_eviction_unit.sv
// ----------------------------------------------------------------------------
// generational_slot_pool_with_eviction_unit
// slot allocator with generation-tagged handles and priority eviction
// ----------------------------------------------------------------------------
// requests enter on the s_ channel (tuser = op), one result per request
// leaves on the m_ channel (tuser = status).
// a refused spawn or an out-of-range index goes straight to the result;
// lookup, report and expire read and check the slot; a spawn pops the
// free stack, or in a full pool first runs the victim scan, which reads
// one slot per cycle from the priority and alpha/age rams.
// one request is in work at a time; s_tready is high only while idle.
// the finished result sits in an output register, so a new request is
// taken while the result waits; a stalled m_ side holds the next result
// in its final step until the register frees.
// reset: synchronous; all slots free, index 0 pops first, generation 1
// is issued next. no clearing pass is needed.
// ----------------------------------------------------------------------------
module generational_slot_pool_with_eviction_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // region_ok, world_locked, priority_req, slot_index, handle_gen, alpha, age
  input  logic [79:0] s_tdata,
  // op
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // result_index, result_gen, evicted, live_slots
  output logic [55:0] m_tdata,
  // status
  output logic [2:0]  m_tuser
);

  gspe_pkg::cmd_t  cmd;
  gspe_pkg::stat_t stat;

  gspe_ctrl u_ctrl (
    .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .stat(stat), .cmd(cmd)
  );

  gspe_dp u_dp (
    .clk(clk), .rst(rst), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .cmd(cmd), .stat(stat), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

endmodule

### test/tb_generational_slot_pool_with_eviction_unit.sv
// ----------------------------------------------------------------------------
// tb_generational_slot_pool_with_eviction_unit
// checks the slot pool against a behavioral model of allocation and eviction
// ----------------------------------------------------------------------------
// a directed table covers refusals, range errors, the first grants and the
// full pool with all slots locked; random traffic then fills, evicts, reports
// and expires slots, with idle cycles on both sides and one long output stall.
// every result is compared field by field with the model's prediction.
// ----------------------------------------------------------------------------
module tb_generational_slot_pool_with_eviction_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    gspe_pkg::op_t op;
    logic        region_ok;
    logic        world_locked;
    logic [7:0]  priority_req;
    logic [8:0]  slot_index;
    logic [31:0] handle_gen;
    logic [7:0]  alpha;
    logic [15:0] age;
  } request_t;

  typedef struct packed {
    gspe_pkg::status_t status;
    logic [7:0]  result_index;
    logic [31:0] result_gen;
    logic        evicted;
    logic [8:0]  live_slots;
  } outcome_t;

  typedef struct {
    request_t req;
    logic     known;
    outcome_t res;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [79:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic [2:0]  m_tuser;

  generational_slot_pool_with_eviction_unit dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // pool model
  logic        live_q   [gspe_pkg::SLOTS];
  logic        locked_q [gspe_pkg::SLOTS];
  logic [7:0]  prio_q   [gspe_pkg::SLOTS];
  logic [7:0]  alpha_q  [gspe_pkg::SLOTS];
  logic [15:0] age_q    [gspe_pkg::SLOTS];
  logic [31:0] gen_q    [gspe_pkg::SLOTS];
  int          free_stk [gspe_pkg::SLOTS];
  int          free_cnt;
  int          live_cnt;
  logic [31:0] gen_next;

  outcome_t pending_outcomes[$];
  int       errors = 0;
  int       table_errors = 0;
  int       results_seen = 0;
  bit       stim_done = 0;
  bit       hold_off = 0;
  bit       hold_done = 0;
  bit       calm = 0;

  function automatic void pool_reset();
    for (int i = 0; i < gspe_pkg::SLOTS; i++) begin
      live_q[i] = 0; locked_q[i] = 0; prio_q[i] = 0; alpha_q[i] = 0;
      age_q[i] = 0; gen_q[i] = 0; free_stk[i] = gspe_pkg::SLOTS - 1 - i;
    end
    free_cnt = gspe_pkg::SLOTS;
    live_cnt = 0;
    gen_next = 1;
  endfunction

  function automatic void free_slot(int s);
    if (!live_q[s]) return;
    live_q[s] = 0;
    free_stk[free_cnt] = s;
    free_cnt++;
    live_cnt--;
  endfunction

  function automatic int find_victim();
    int best;
    best = -1;
    for (int i = 0; i < gspe_pkg::SLOTS; i++) begin
      if (!live_q[i] || locked_q[i]) continue;
      if (best < 0) best = i;
      else if (prio_q[i] != prio_q[best]) begin
        if (prio_q[i] < prio_q[best]) best = i;
      end else if (alpha_q[i] != alpha_q[best]) begin
        if (alpha_q[i] < alpha_q[best]) best = i;
      end else if (age_q[i] > age_q[best]) best = i;
    end
    return best;
  endfunction

  function automatic outcome_t pool_apply(request_t r);
    outcome_t o;
    int v, s;
    o = '0;
    o.status = gspe_pkg::ST_OK;
    if (r.op == gspe_pkg::OP_SPAWN) begin
      if (!r.region_ok) o.status = gspe_pkg::ST_NOREG;
      else begin
        v = 0;
        if (free_cnt == 0) begin
          v = find_victim();
          if (v >= 0) begin
            free_slot(v);
            o.evicted = 1'b1;
          end
        end
        if (v < 0) o.status = gspe_pkg::ST_FULL;
        else begin
          free_cnt--;
          s = free_stk[free_cnt];
          live_q[s] = 1; locked_q[s] = r.world_locked; prio_q[s] = r.priority_req;
          alpha_q[s] = 0; age_q[s] = 0; gen_q[s] = gen_next;
          gen_next++;
          if (gen_next == 0) gen_next = 1;
          live_cnt++;
          o.result_index = 8'(s);
          o.result_gen = gen_q[s];
        end
      end
    end else begin
      o.result_index = r.slot_index[7:0];
      if (r.slot_index >= gspe_pkg::SLOTS) o.status = gspe_pkg::ST_BAD;
      else begin
        s = int'(r.slot_index);
        o.result_gen = gen_q[s];
        if (r.op == gspe_pkg::OP_LOOKUP) begin
          if (!live_q[s] || gen_q[s] != r.handle_gen) o.status = gspe_pkg::ST_BAD;
        end else if (!live_q[s]) o.status = gspe_pkg::ST_DEAD;
        else if (r.op == gspe_pkg::OP_REPORT) begin
          alpha_q[s] = r.alpha;
          age_q[s] = r.age;
        end else free_slot(s);
      end
    end
    o.live_slots = 9'(live_cnt);
    return o;
  endfunction

  function automatic request_t mk_req(gspe_pkg::op_t op, logic hr, logic lk, logic [7:0] pr,
                                      logic [8:0] ix, logic [31:0] g,
                                      logic [7:0] a, logic [15:0] ag);
    request_t r;
    r.op = op; r.region_ok = hr; r.world_locked = lk; r.priority_req = pr;
    r.slot_index = ix; r.handle_gen = g; r.alpha = a; r.age = ag;
    return r;
  endfunction

  function automatic int live_pick();
    int s;
    for (int k = 0; k < 8; k++) begin
      s = $urandom_range(gspe_pkg::SLOTS - 1);
      if (live_q[s]) return s;
    end
    return $urandom_range(gspe_pkg::SLOTS - 1);
  endfunction

  function automatic request_t rand_req();
    request_t r;
    int sel, s;
    r = '0;
    r.region_ok = 1;
    r.priority_req = 8'($urandom);
    r.world_locked = ($urandom_range(15) == 0);
    r.handle_gen = $urandom;
    r.alpha = 8'($urandom);
    r.age = 16'($urandom);
    sel = $urandom_range(99);
    s = live_pick();
    r.slot_index = 9'(s);
    if (sel < 40) begin
      r.op = gspe_pkg::OP_SPAWN;
      if ($urandom_range(19) == 0) r.region_ok = 0;
    end else if (sel < 60) begin
      r.op = gspe_pkg::OP_LOOKUP;
      if ($urandom_range(3) != 0) r.handle_gen = gen_q[s];
    end else if (sel < 80) r.op = gspe_pkg::OP_REPORT;
    else r.op = gspe_pkg::OP_EXPIRE;
    if ($urandom_range(24) == 0) r.slot_index = 9'($urandom_range(511, gspe_pkg::SLOTS));
    return r;
  endfunction

  task automatic send_request(request_t r);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 25) @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser <= r.op;
    s_tdata <= {{(80 - 75){1'b0}}, r.age, r.alpha, r.handle_gen, r.slot_index,
                r.priority_req, r.world_locked, r.region_ok};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_outcomes.push_back(pool_apply(r));
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  row_t dir_rows[$];

  task automatic add_row(request_t r, logic known, outcome_t o);
    row_t x;
    x.req = r; x.known = known; x.res = o;
    dir_rows.push_back(x);
  endtask

  initial begin
    row_t x;
    pool_reset();
    add_row(mk_req(gspe_pkg::OP_SPAWN, 0, 0, 8'hff, 0, 0, 0, 0), 1,
            {gspe_pkg::ST_NOREG, 8'd0, 32'd0, 1'b0, 9'd0});
    add_row(mk_req(gspe_pkg::OP_LOOKUP, 0, 0, 0, 9'd511, 32'hffffffff, 0, 0), 1,
            {gspe_pkg::ST_BAD, 8'hff, 32'd0, 1'b0, 9'd0});
    add_row(mk_req(gspe_pkg::OP_REPORT, 0, 0, 0, 9'd256, 0, 8'hff, 16'hffff), 1,
            {gspe_pkg::ST_BAD, 8'h00, 32'd0, 1'b0, 9'd0});
    add_row(mk_req(gspe_pkg::OP_EXPIRE, 0, 0, 0, 9'd5, 0, 0, 0), 1,
            {gspe_pkg::ST_DEAD, 8'd5, 32'd0, 1'b0, 9'd0});
    add_row(mk_req(gspe_pkg::OP_SPAWN, 1, 0, 8'h00, 0, 0, 0, 0), 1,
            {gspe_pkg::ST_OK, 8'd0, 32'd1, 1'b0, 9'd1});
    add_row(mk_req(gspe_pkg::OP_SPAWN, 1, 1, 8'hff, 0, 0, 0, 0), 1,
            {gspe_pkg::ST_OK, 8'd1, 32'd2, 1'b0, 9'd2});
    add_row(mk_req(gspe_pkg::OP_LOOKUP, 0, 0, 0, 9'd1, 32'd2, 0, 0), 1,
            {gspe_pkg::ST_OK, 8'd1, 32'd2, 1'b0, 9'd2});
    add_row(mk_req(gspe_pkg::OP_LOOKUP, 0, 0, 0, 9'd1, 32'd3, 0, 0), 1,
            {gspe_pkg::ST_BAD, 8'd1, 32'd2, 1'b0, 9'd2});
    add_row(mk_req(gspe_pkg::OP_REPORT, 0, 0, 0, 9'd0, 0, 8'hff, 16'hffff), 1,
            {gspe_pkg::ST_OK, 8'd0, 32'd1, 1'b0, 9'd2});
    add_row(mk_req(gspe_pkg::OP_EXPIRE, 0, 0, 0, 9'd0, 0, 0, 0), 1,
            {gspe_pkg::ST_OK, 8'd0, 32'd1, 1'b0, 9'd1});
    add_row(mk_req(gspe_pkg::OP_LOOKUP, 0, 0, 0, 9'd0, 32'd1, 0, 0), 1,
            {gspe_pkg::ST_BAD, 8'd0, 32'd1, 1'b0, 9'd1});
    add_row(mk_req(gspe_pkg::OP_REPORT, 0, 0, 0, 9'd0, 0, 0, 0), 1,
            {gspe_pkg::ST_DEAD, 8'd0, 32'd1, 1'b0, 9'd1});
    add_row(mk_req(gspe_pkg::OP_SPAWN, 1, 0, 8'h10, 0, 0, 0, 0), 1,
            {gspe_pkg::ST_OK, 8'd0, 32'd3, 1'b0, 9'd2});
    // fill the pool with locked slots, then spawn into a full locked pool
    for (int i = 0; i < gspe_pkg::SLOTS - 2; i++)
      add_row(mk_req(gspe_pkg::OP_SPAWN, 1, 1, 8'(i), 0, 0, 0, 0), 0, '0);
    add_row(mk_req(gspe_pkg::OP_SPAWN, 1, 0, 8'h00, 0, 0, 0, 0), 0, '0);
    add_row(mk_req(gspe_pkg::OP_EXPIRE, 0, 0, 0, 9'd0, 0, 0, 0), 0, '0);
    add_row(mk_req(gspe_pkg::OP_SPAWN, 1, 1, 8'h00, 0, 0, 0, 0), 0, '0);
    add_row(mk_req(gspe_pkg::OP_SPAWN, 1, 0, 8'h00, 0, 0, 0, 0), 1,
            {gspe_pkg::ST_FULL, 8'd0, 32'd0, 1'b0, 9'd256});
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i]) begin
      x = dir_rows[i];
      send_request(x.req);
      if (x.known && pending_outcomes[$] !== x.res) begin
        table_errors++;
        if (table_errors <= 10)
          $display("row %0d: table %h, model %h", i, x.res, pending_outcomes[$]);
      end
    end
    // free the locked pool so random traffic can evict
    for (int s = 0; s < gspe_pkg::SLOTS; s++)
      send_request(mk_req(gspe_pkg::OP_EXPIRE, 0, 0, 0, 9'(s), 0, 0, 0));
    for (int n = 0; n < 720; n++) begin
      calm = (n >= 300 && n < 450);
      if (n == 600) hold_off = 1;
      send_request(rand_req());
    end
    stim_done = 1;
  end

  // receiver: random stalls plus one long hold-off while requests keep coming
  initial begin
    int cnt;
    @(negedge clk);
    forever begin
      if (hold_off && !hold_done) begin
        m_tready <= 1'b0;
        cnt = 0;
        while (cnt < 400) begin
          @(negedge clk);
          cnt++;
        end
        hold_done = 1;
      end
      m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 25);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    outcome_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = {gspe_pkg::status_t'(m_tuser), m_tdata[7:0], m_tdata[39:8], m_tdata[40],
             m_tdata[49:41]};
      results_seen++;
      if (pending_outcomes.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_outcomes.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10)
            $display("result %0d: status %0d/%0d index %0d/%0d gen %h/%h ev %b/%b live %0d/%0d",
                     results_seen, want.status, got.status, want.result_index,
                     got.result_index, want.result_gen, got.result_gen, want.evicted,
                     got.evicted, want.live_slots, got.live_slots);
        end
      end
    end
  end

  initial begin
    wait (stim_done);
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && table_errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #20ms;
    $display("TEST FAILED");
    $finish;
  end
endmodule
